>>> rtl/core/qvs_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and state codes of the skinning core
package qvs_pkg;

    localparam int MAX_JOINTS = 256;
    localparam int JT_AW      = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int JT_W       = 160;   // rotation 64 bits, then offsets x, y, z

    localparam int P1_W = 48;          // quaternion times position
    localparam int T_W  = 37;          // rotated cross term, q.16
    localparam int P2_W = 53;          // quaternion times cross term
    localparam int SUM_W = 56;
    localparam int R_W  = 42;
    localparam int S_W  = 43;
    localparam int C_W  = 60;
    localparam int ACC_W = 48;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_WEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CROSS,
        ST_MUL2,
        ST_ROT,
        ST_SCALE,
        ST_ACC
    } state_t;

endpackage

>>> rtl/core/quaternion_weighted_vertex_skinning_core.sv
`timescale 1ns / 1ps
// quaternion joint skinning core: joint table, rotate, offset, weight and accumulate
//
// Input channel s_*: one request per cycle handshake while s_ready is high. A request
// with s_action low loads joint entry s_joint_index (quaternion and offset).
// A request with s_action high rotates s_vec_* by the joint's quaternion, adds the
// offset, scales by s_bias and adds the result into the vertex accumulator.
// A weight runs as one table read, then three multiply steps, the first two
// followed by a rounding step, then a round and accumulate; s_ready is low
// meanwhile. On a weight with s_last_weight high, the clipped vertex is loaded
// into the output register m_* in the accumulate cycle, which raises m_valid,
// and the accumulator is cleared.
// Output channel m_*: the result stays until m_ready; a new request is taken
// while it waits. A second result held back by a stalled receiver keeps the
// core in its accumulate step until the output register frees.
// Reset clears the accumulator and the control state; the joint table is not
// cleared and must be written before a weight refers to an entry.
module quaternion_weighted_vertex_skinning_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [7:0]          s_joint_index,
    input  logic signed [31:0]  s_vec_x,
    input  logic signed [31:0]  s_vec_y,
    input  logic signed [31:0]  s_vec_z,
    input  logic signed [15:0]  s_quat_w,
    input  logic signed [15:0]  s_quat_x,
    input  logic signed [15:0]  s_quat_y,
    input  logic signed [15:0]  s_quat_z,
    input  logic [15:0]         s_bias,
    input  logic                s_last_weight,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_vertex_x,
    output logic signed [31:0]  m_vertex_y,
    output logic signed [31:0]  m_vertex_z,
    output logic                m_saturated
);
    import qvs_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    state_t state_reg, state_next;

    logic s_fire;
    logic ram_we, ram_re;
    logic [JT_W-1:0] ram_wdata, ram_rdata;
    logic [JT_AW-1:0] ram_addr;
    logic idx_ok;

    // operands of the weight in flight
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [15:0]        bias_reg;
    logic               last_reg, ok_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;

    logic signed [P1_W-1:0] a_reg [6];
    logic signed [T_W-1:0]  tx_reg, ty_reg, tz_reg;
    logic signed [P2_W-1:0] b_reg [9];
    logic signed [S_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic signed [C_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic signed [ACC_W-1:0] accx_reg, accy_reg, accz_reg;

    logic               m_valid_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic               sat_reg;

    // step and output control
    logic out_free, acc_go, lat_ops, do_mul1, do_cross, do_mul2, do_rot, do_scale;

    assign s_fire   = s_valid && s_ready;
    assign idx_ok   = int'(s_joint_index) < MAX_JOINTS;
    assign ram_addr = JT_AW'(s_joint_index);
    assign ram_wdata = {s_quat_w, s_quat_x, s_quat_y, s_quat_z, s_vec_x, s_vec_y, s_vec_z};
    assign out_free = !m_valid_reg || m_ready;

    qvs_ram #(.WIDTH(JT_W), .DEPTH(MAX_JOINTS)) u_joint_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire && s_action == ACT_WEIGHT) state_next = ST_READ;
            ST_READ:  state_next = ST_CROSS;
            ST_CROSS: state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_ROT;
            ST_ROT:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_ACC;
            ST_ACC:   if (!last_reg || out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        lat_ops  = 1'b0;
        do_mul1  = 1'b0;
        do_cross = 1'b0;
        do_mul2  = 1'b0;
        do_rot   = 1'b0;
        do_scale = 1'b0;
        acc_go   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                ram_we  = s_fire && s_action == ACT_WRITE && idx_ok;
                ram_re  = s_fire && s_action == ACT_WEIGHT;
                lat_ops = ram_re;
            end
            ST_READ:  do_mul1  = 1'b1;
            ST_CROSS: do_cross = 1'b1;
            ST_MUL2:  do_mul2  = 1'b1;
            ST_ROT:   do_rot   = 1'b1;
            ST_SCALE: do_scale = 1'b1;
            ST_ACC:   acc_go   = !last_reg || out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    logic signed [15:0] rq_w, rq_x, rq_y, rq_z;
    logic signed [31:0] ro_x, ro_y, ro_z;

    always_comb begin
        rq_w = ok_reg ? $signed(ram_rdata[159:144]) : '0;
        rq_x = ok_reg ? $signed(ram_rdata[143:128]) : '0;
        rq_y = ok_reg ? $signed(ram_rdata[127:112]) : '0;
        rq_z = ok_reg ? $signed(ram_rdata[111:96])  : '0;
        ro_x = ok_reg ? $signed(ram_rdata[95:64])   : '0;
        ro_y = ok_reg ? $signed(ram_rdata[63:32])   : '0;
        ro_z = ok_reg ? $signed(ram_rdata[31:0])    : '0;
    end

    logic signed [P1_W+1:0] dx, dy, dz;
    logic signed [SUM_W-1:0] ux, uy, uz;
    logic signed [R_W-1:0]   rx, ry, rz;
    logic signed [C_W-1:0]   cr_x, cr_y, cr_z;
    logic signed [ACC_W:0]   nx, ny, nz;
    logic signed [ACC_W-1:0] fx, fy, fz;
    logic signed [31:0]      clx, cly, clz;
    logic                    satx, saty, satz;

    always_comb begin
        // doubled cross product, round half up to q.16
        dx = ((50'(a_reg[0]) - 50'(a_reg[1])) <<< 1) + 50'sd8192;
        dy = ((50'(a_reg[2]) - 50'(a_reg[3])) <<< 1) + 50'sd8192;
        dz = ((50'(a_reg[4]) - 50'(a_reg[5])) <<< 1) + 50'sd8192;

        ux = (SUM_W'(px_reg) <<< 14) + SUM_W'(b_reg[0]) + SUM_W'(b_reg[1])
             - SUM_W'(b_reg[2]) + SUM_W'(56'sd8192);
        uy = (SUM_W'(py_reg) <<< 14) + SUM_W'(b_reg[3]) + SUM_W'(b_reg[4])
             - SUM_W'(b_reg[5]) + SUM_W'(56'sd8192);
        uz = (SUM_W'(pz_reg) <<< 14) + SUM_W'(b_reg[6]) + SUM_W'(b_reg[7])
             - SUM_W'(b_reg[8]) + SUM_W'(56'sd8192);
        rx = R_W'(ux >>> 14);
        ry = R_W'(uy >>> 14);
        rz = R_W'(uz >>> 14);

        cr_x = (cx_reg + C_W'(60'sd16384)) >>> 15;
        cr_y = (cy_reg + C_W'(60'sd16384)) >>> 15;
        cr_z = (cz_reg + C_W'(60'sd16384)) >>> 15;
        nx = (ACC_W+1)'(accx_reg) + (ACC_W+1)'(cr_x);
        ny = (ACC_W+1)'(accy_reg) + (ACC_W+1)'(cr_y);
        nz = (ACC_W+1)'(accz_reg) + (ACC_W+1)'(cr_z);
        fx = (nx > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX :
             (nx < (ACC_W+1)'(ACC_MIN)) ? ACC_MIN : ACC_W'(nx);
        fy = (ny > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX :
             (ny < (ACC_W+1)'(ACC_MIN)) ? ACC_MIN : ACC_W'(ny);
        fz = (nz > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX :
             (nz < (ACC_W+1)'(ACC_MIN)) ? ACC_MIN : ACC_W'(nz);

        // clip to 32 bits
        satx = fx != ACC_W'($signed(fx[31:0]));
        saty = fy != ACC_W'($signed(fy[31:0]));
        satz = fz != ACC_W'($signed(fz[31:0]));
        clx  = satx ? (fx[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : fx[31:0];
        cly  = saty ? (fy[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : fy[31:0];
        clz  = satz ? (fz[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : fz[31:0];
    end

    always_ff @(posedge aclk) begin
        if (lat_ops) begin
            px_reg   <= s_vec_x;
            py_reg   <= s_vec_y;
            pz_reg   <= s_vec_z;
            bias_reg <= s_bias;
            last_reg <= s_last_weight;
            ok_reg   <= idx_ok;
        end
        if (do_mul1) begin
            qw_reg <= rq_w;
            qx_reg <= rq_x;
            qy_reg <= rq_y;
            qz_reg <= rq_z;
            ox_reg <= ro_x;
            oy_reg <= ro_y;
            oz_reg <= ro_z;
            a_reg[0] <= P1_W'(rq_y) * P1_W'(pz_reg);
            a_reg[1] <= P1_W'(rq_z) * P1_W'(py_reg);
            a_reg[2] <= P1_W'(rq_z) * P1_W'(px_reg);
            a_reg[3] <= P1_W'(rq_x) * P1_W'(pz_reg);
            a_reg[4] <= P1_W'(rq_x) * P1_W'(py_reg);
            a_reg[5] <= P1_W'(rq_y) * P1_W'(px_reg);
        end
        if (do_cross) begin
            tx_reg <= T_W'(dx >>> 14);
            ty_reg <= T_W'(dy >>> 14);
            tz_reg <= T_W'(dz >>> 14);
        end
        if (do_mul2) begin
            b_reg[0] <= P2_W'(qw_reg) * P2_W'(tx_reg);
            b_reg[1] <= P2_W'(qy_reg) * P2_W'(tz_reg);
            b_reg[2] <= P2_W'(qz_reg) * P2_W'(ty_reg);
            b_reg[3] <= P2_W'(qw_reg) * P2_W'(ty_reg);
            b_reg[4] <= P2_W'(qz_reg) * P2_W'(tx_reg);
            b_reg[5] <= P2_W'(qx_reg) * P2_W'(tz_reg);
            b_reg[6] <= P2_W'(qw_reg) * P2_W'(tz_reg);
            b_reg[7] <= P2_W'(qx_reg) * P2_W'(ty_reg);
            b_reg[8] <= P2_W'(qy_reg) * P2_W'(tx_reg);
        end
        if (do_rot) begin
            sx_reg <= S_W'(rx) + S_W'(ox_reg);
            sy_reg <= S_W'(ry) + S_W'(oy_reg);
            sz_reg <= S_W'(rz) + S_W'(oz_reg);
        end
        if (do_scale) begin
            cx_reg <= C_W'(sx_reg) * C_W'($signed({1'b0, bias_reg}));
            cy_reg <= C_W'(sy_reg) * C_W'($signed({1'b0, bias_reg}));
            cz_reg <= C_W'(sz_reg) * C_W'($signed({1'b0, bias_reg}));
        end
        if (acc_go && last_reg) begin
            vx_reg  <= clx;
            vy_reg  <= cly;
            vz_reg  <= clz;
            sat_reg <= satx || saty || satz;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accx_reg    <= '0;
            accy_reg    <= '0;
            accz_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (acc_go) begin
                accx_reg <= last_reg ? '0 : fx;
                accy_reg <= last_reg ? '0 : fy;
                accz_reg <= last_reg ? '0 : fz;
            end
            if (acc_go && last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_vertex_x  = vx_reg;
    assign m_vertex_y  = vy_reg;
    assign m_vertex_z  = vz_reg;
    assign m_saturated = sat_reg;
endmodule

>>> rtl/core/qvs_ram.sv
`timescale 1ns / 1ps
// generic single-port-write, registered-read ram
module qvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> rtl/core/qvs_checker.sv
`timescale 1ns / 1ps
// port-level checks of the skinning core and their bind
module qvs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_vertex_x,
    input logic        m_saturated
);
    import qvs_pkg::*;

    // stalled result is held
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_vertex_x) && $stable(m_saturated))
        else $error("result changed while stalled");

    // no result can appear right after a request is taken
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result too early");

    // after a weight is taken, s_ready drops while it is in flight
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action == ACT_WEIGHT |=> !s_ready)
        else $error("request taken while weight in flight");
endmodule

bind quaternion_weighted_vertex_skinning_core qvs_checker u_qvs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_action    (s_action),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_vertex_x  (m_vertex_x),
    .m_saturated (m_saturated)
);
